[sv/postfix_expression_evaluator_defines.svh]
// Assertion macros used by the pfe_checker module.
`ifndef POSTFIX_EXPRESSION_EVALUATOR_DEFINES_SVH
`define POSTFIX_EXPRESSION_EVALUATOR_DEFINES_SVH

// Same-cycle implication, quiet while reset is asserted
`define PFE_ASSERT_SAME(lbl, ante, cons) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error("postfix evaluator check failed");

// Next-cycle implication, quiet while reset is asserted
`define PFE_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error("postfix evaluator check failed");

// Next-cycle implication that also covers the reset cycles
`define PFE_ASSERT_NEXT_ALWAYS(lbl, ante, cons) \
    lbl: assert property (@(posedge aclk) (ante) |=> (cons)) \
        else $error("postfix evaluator check failed");

`endif

[sv/pfe_pkg.sv]
package pfe_pkg;

    // Stack capacity and the split between register cache and memory
    localparam int STACK_DEPTH = 64;
    localparam int CACHE_DEPTH = 4;   // top entries kept in flops, at least 2
    localparam int QUEUE_DEPTH = 4;   // power of two

    localparam int CHAR_W  = 8;
    localparam int DIGIT_W = 4;
    localparam int VALUE_W = 32;

    localparam int MEM_AW = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
    localparam int CNT_W  = $clog2(STACK_DEPTH + 1);
    localparam int CC_W   = $clog2(CACHE_DEPTH + 1);
    localparam int QA_W   = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int QC_W   = $clog2(QUEUE_DEPTH + 1);

    // Character codes
    localparam logic [CHAR_W-1:0] CHAR_ZERO  = 8'h30;
    localparam logic [CHAR_W-1:0] CHAR_ONE   = 8'h31;
    localparam logic [CHAR_W-1:0] CHAR_NINE  = 8'h39;
    localparam logic [CHAR_W-1:0] CHAR_PLUS  = 8'h2B;
    localparam logic [CHAR_W-1:0] CHAR_MINUS = 8'h2D;
    localparam logic [CHAR_W-1:0] CHAR_STAR  = 8'h2A;

    // Value read from an empty stack
    localparam logic [VALUE_W-1:0] EMPTY_VALUE = 32'hFFFF_FFFF;

    typedef enum logic [2:0] {
        OP_NOP,
        OP_PUSH,
        OP_ADD,
        OP_SUB,
        OP_MUL
    } op_t;

    // Classified character as it travels from front to back
    typedef struct packed {
        op_t                op;
        logic [DIGIT_W-1:0] digit;
        logic               last;
    } cmd_t;

endpackage

[sv/pfe_front.sv]
module pfe_front
    import pfe_pkg::*;
(
    input  logic              s_valid,
    output logic              s_ready,
    input  logic [CHAR_W-1:0] s_character,
    input  logic              s_last_char,
    input  logic              q_full,
    output logic              q_wr_en,
    output cmd_t              q_cmd
);

    logic [CHAR_W-1:0] digit_code;

    assign s_ready    = !q_full;
    assign q_wr_en    = s_valid && !q_full;
    assign digit_code = s_character - CHAR_ZERO;

    // Decode the character into a stack command
    always_comb begin
        q_cmd.digit = digit_code[DIGIT_W-1:0];
        q_cmd.last  = s_last_char;
        priority if (s_character >= CHAR_ONE && s_character <= CHAR_NINE) begin
            q_cmd.op = OP_PUSH;
        end else if (s_character == CHAR_PLUS) begin
            q_cmd.op = OP_ADD;
        end else if (s_character == CHAR_MINUS) begin
            q_cmd.op = OP_SUB;
        end else if (s_character == CHAR_STAR) begin
            q_cmd.op = OP_MUL;
        end else begin
            q_cmd.op = OP_NOP;
        end
    end

endmodule

[sv/pfe_queue.sv]
module pfe_queue
    import pfe_pkg::*;
(
    input  logic aclk,
    input  logic aresetn,
    input  logic wr_en,
    input  cmd_t wr_cmd,
    output logic full,
    output logic rd_valid,
    input  logic rd_en,
    output cmd_t rd_cmd
);

    cmd_t            slot_reg [QUEUE_DEPTH];
    logic [QA_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [QA_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [QC_W-1:0] cnt_reg, cnt_next;
    logic            do_wr, do_rd;

    assign full     = (cnt_reg == QC_W'(QUEUE_DEPTH));
    assign rd_valid = (cnt_reg != '0);
    assign rd_cmd   = slot_reg[rd_ptr_reg];
    assign do_wr    = wr_en && !full;
    assign do_rd    = rd_en && rd_valid;

    // Pointer and occupancy update
    always_comb begin
        wr_ptr_next = do_wr ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = do_rd ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        cnt_next    = cnt_reg + QC_W'(do_wr) - QC_W'(do_rd);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    // Slot storage
    always_ff @(posedge aclk) begin
        if (do_wr) begin
            slot_reg[wr_ptr_reg] <= wr_cmd;
        end
    end

endmodule

[sv/pfe_back.sv]
module pfe_back
    import pfe_pkg::*;
(
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               q_valid,
    input  cmd_t               q_cmd,
    output logic               q_take,
    output logic               m_valid,
    input  logic               m_ready,
    output logic [VALUE_W-1:0] m_value,
    output logic               m_overflowed
);

    // Stack below the cached top entries
    logic [VALUE_W-1:0] stack_mem [STACK_DEPTH];

    // Top-of-stack cache, index 0 is the top
    logic [VALUE_W-1:0] cache_reg [CACHE_DEPTH];
    logic [VALUE_W-1:0] cache_next [CACHE_DEPTH];
    logic [CC_W-1:0]    ccnt_reg, ccnt_next;
    logic [CNT_W-1:0]   mcnt_reg, mcnt_next;
    logic               pend_reg, pend_next;
    logic [VALUE_W-1:0] rdata_reg;
    logic               ovf_reg, ovf_next;
    logic               m_valid_reg, m_valid_next;
    logic [VALUE_W-1:0] m_value_reg, m_value_next;
    logic               m_ovf_reg, m_ovf_next;

    logic [VALUE_W-1:0] eff [CACHE_DEPTH];
    logic [CC_W-1:0]    eff_cnt;
    logic [VALUE_W-1:0] a_val, b_val, prod, ar_res, push_val;
    logic               is_arith, ok_two, ok_one, data_ok, out_free, go;
    logic               spill, issue, ovf_set;
    logic [VALUE_W-1:0] spill_data, res;
    logic [CNT_W-1:0]   rd_cnt;

    // Cache as seen this cycle: flops plus the refill word landing at the bottom
    always_comb begin
        for (int i = 0; i < CACHE_DEPTH; i++) begin
            eff[i] = (CC_W'(i) < ccnt_reg) ? cache_reg[i] : rdata_reg;
        end
    end
    assign eff_cnt = ccnt_reg + CC_W'(pend_reg);

    // Operands and the arithmetic unit
    assign b_val = (eff_cnt != '0) ? eff[0] : EMPTY_VALUE;
    assign a_val = (eff_cnt > CC_W'(1)) ? eff[1] : EMPTY_VALUE;
    assign prod  = a_val * b_val;

    always_comb begin
        unique case (q_cmd.op)
            OP_ADD:  ar_res = a_val + b_val;
            OP_SUB:  ar_res = a_val - b_val;
            OP_MUL:  ar_res = prod;
            default: ar_res = '0;
        endcase
    end

    assign is_arith = (q_cmd.op == OP_ADD) || (q_cmd.op == OP_SUB) || (q_cmd.op == OP_MUL);
    assign push_val = is_arith ? ar_res : VALUE_W'(q_cmd.digit);

    // Wait until the entries the command reads sit in the cache
    assign ok_two   = (eff_cnt >= CC_W'(2)) || (mcnt_reg == '0);
    assign ok_one   = (eff_cnt != '0) || (mcnt_reg == '0);
    assign out_free = !m_valid_reg || m_ready;

    always_comb begin
        unique case (q_cmd.op)
            OP_ADD, OP_SUB, OP_MUL: data_ok = ok_two;
            OP_PUSH, OP_NOP:        data_ok = !q_cmd.last || ok_one;
            default:                data_ok = 1'b1;
        endcase
    end

    assign go     = q_valid && data_ok && (!q_cmd.last || out_free);
    assign q_take = go;

    // Execute one command on the cache
    always_comb begin
        logic [CNT_W:0] held;
        cache_next = eff;
        ccnt_next  = eff_cnt;
        spill      = 1'b0;
        spill_data = eff[CACHE_DEPTH-1];
        ovf_set    = 1'b0;
        res        = EMPTY_VALUE;
        held       = '0;
        if (go) begin
            // operator pops B then A
            for (int p = 0; p < 2; p++) begin
                if (is_arith && ccnt_next != '0) begin
                    for (int i = 0; i < CACHE_DEPTH - 1; i++) begin
                        cache_next[i] = cache_next[i + 1];
                    end
                    ccnt_next = ccnt_next - 1'b1;
                end
            end
            // push or set overflow; spill the bottom entry if the cache is full
            held = {1'b0, mcnt_reg} + (CNT_W + 1)'(ccnt_next);
            if (is_arith || q_cmd.op == OP_PUSH) begin
                if (held == (CNT_W + 1)'(STACK_DEPTH)) begin
                    ovf_set = 1'b1;
                end else begin
                    if (ccnt_next == CC_W'(CACHE_DEPTH)) begin
                        spill      = 1'b1;
                        spill_data = cache_next[CACHE_DEPTH-1];
                    end else begin
                        ccnt_next = ccnt_next + 1'b1;
                    end
                    for (int i = CACHE_DEPTH - 1; i > 0; i--) begin
                        cache_next[i] = cache_next[i - 1];
                    end
                    cache_next[0] = push_val;
                end
            end
            // end of expression: report the top and pop it
            if (q_cmd.last) begin
                if (ccnt_next != '0) begin
                    res = cache_next[0];
                    for (int i = 0; i < CACHE_DEPTH - 1; i++) begin
                        cache_next[i] = cache_next[i + 1];
                    end
                    ccnt_next = ccnt_next - 1'b1;
                end
            end
        end
    end

    // Refill the cache from memory, one word per cycle unless spilling or full
    assign issue     = (mcnt_reg != '0) && !spill && (ccnt_next < CC_W'(CACHE_DEPTH));
    assign rd_cnt    = mcnt_reg - 1'b1;
    assign pend_next = issue;
    assign mcnt_next = mcnt_reg + CNT_W'(spill) - CNT_W'(issue);

    // Sticky overflow and the output register
    always_comb begin
        ovf_next     = ovf_reg || ovf_set;
        m_valid_next = m_valid_reg && !m_ready;
        m_value_next = m_value_reg;
        m_ovf_next   = m_ovf_reg;
        if (go && q_cmd.last) begin
            m_valid_next = 1'b1;
            m_value_next = res;
            m_ovf_next   = ovf_reg || ovf_set;
            ovf_next     = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            ccnt_reg    <= '0;
            mcnt_reg    <= '0;
            pend_reg    <= 1'b0;
            ovf_reg     <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            ccnt_reg    <= ccnt_next;
            mcnt_reg    <= mcnt_next;
            pend_reg    <= pend_next;
            ovf_reg     <= ovf_next;
            m_valid_reg <= m_valid_next;
        end
    end

    // Payload registers
    always_ff @(posedge aclk) begin
        cache_reg   <= cache_next;
        m_value_reg <= m_value_next;
        m_ovf_reg   <= m_ovf_next;
    end

    // Stack memory: one write and one registered read per cycle
    always_ff @(posedge aclk) begin
        if (spill) begin
            stack_mem[mcnt_reg[MEM_AW-1:0]] <= spill_data;
        end
        if (issue) begin
            rdata_reg <= stack_mem[rd_cnt[MEM_AW-1:0]];
        end
    end

    assign m_valid      = m_valid_reg;
    assign m_value      = m_value_reg;
    assign m_overflowed = m_ovf_reg;

endmodule

[sv/postfix_expression_evaluator.sv]
// Channel   Ports                                   Direction   Moves
// -------   -------------------------------------   ---------   ----------------------
// input     s_valid s_ready s_character s_last_char  in          one character per transfer
// result    m_valid m_ready m_value m_overflowed     out         one value per expression
//
// One character per cycle while s_ready is high; results go through the queue and the
// output register. The top four stack entries live in flops; an operator waits for each
// of its two operands that must come back from the stack memory (one read per cycle).
// Reset clears the stack counts and overflow flag at once; memory contents are not cleared.
// A stalled result holds in its output register while the back end keeps working
// until the next last character; a short queue absorbs input during back-end waits.
module postfix_expression_evaluator
    import pfe_pkg::*;
(
    input  logic                      aclk,
    input  logic                      aresetn,
    input  logic                      s_valid,
    output logic                      s_ready,
    input  logic [CHAR_W-1:0]         s_character,
    input  logic                      s_last_char,
    output logic                      m_valid,
    input  logic                      m_ready,
    output logic signed [VALUE_W-1:0] m_value,
    output logic                      m_overflowed
);

    logic               q_full, q_wr_en, q_valid, q_take;
    cmd_t               q_wr_cmd, q_rd_cmd;
    logic [VALUE_W-1:0] value_raw;

    pfe_front u_front (
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .s_character (s_character),
        .s_last_char (s_last_char),
        .q_full      (q_full),
        .q_wr_en     (q_wr_en),
        .q_cmd       (q_wr_cmd)
    );

    pfe_queue u_queue (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .wr_en    (q_wr_en),
        .wr_cmd   (q_wr_cmd),
        .full     (q_full),
        .rd_valid (q_valid),
        .rd_en    (q_take),
        .rd_cmd   (q_rd_cmd)
    );

    pfe_back u_back (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .q_valid      (q_valid),
        .q_cmd        (q_rd_cmd),
        .q_take       (q_take),
        .m_valid      (m_valid),
        .m_ready      (m_ready),
        .m_value      (value_raw),
        .m_overflowed (m_overflowed)
    );

    assign m_value = signed'(value_raw);

endmodule

[sv/pfe_checker.sv]
`include "postfix_expression_evaluator_defines.svh"

module pfe_checker
    import pfe_pkg::*;
(
    input logic               aclk,
    input logic               aresetn,
    input logic               s_valid,
    input logic               s_ready,
    input logic               m_valid,
    input logic               m_ready,
    input logic [VALUE_W-1:0] m_value,
    input logic               m_overflowed
);

    // A stalled result stays put
    `PFE_ASSERT_NEXT(a_result_hold, m_valid && !m_ready, m_valid && $stable(m_value))
    `PFE_ASSERT_NEXT(a_flag_hold, m_valid && !m_ready, $stable(m_overflowed))

    // Reset empties the queue and the output register
    `PFE_ASSERT_NEXT_ALWAYS(a_reset_idle, !aresetn, s_ready && !m_valid)

    // The queue only fills on an input transfer
    `PFE_ASSERT_SAME(a_ready_drop, $fell(s_ready), $past(s_valid && s_ready))

endmodule

bind postfix_expression_evaluator pfe_checker u_pfe_checker (.*);

[dv/postfix_checker.sv]
// Watches both channels of the evaluator, predicts each expression result
// from the accepted characters and compares it with the result transfer.
module postfix_checker
    import pfe_pkg::*;
(
    input  logic                      aclk,
    input  logic                      aresetn,
    input  logic                      s_valid,
    input  logic                      s_ready,
    input  logic [CHAR_W-1:0]         s_character,
    input  logic                      s_last_char,
    input  logic                      m_valid,
    input  logic                      m_ready,
    input  logic signed [VALUE_W-1:0] m_value,
    input  logic                      m_overflowed,
    output int                        fail_count,
    output int                        pending,
    output int                        checked_count,
    output int                        overflow_count,
    output int                        stall_count
);

    typedef struct {
        logic [VALUE_W-1:0] value;
        logic               overflowed;
    } expr_result_t;

    // Expected results in transfer order
    expr_result_t expected_results[$];

    // Shadow stack of the block
    logic [VALUE_W-1:0] stack_mem [STACK_DEPTH];
    int                 stack_fill;
    logic               push_dropped;

    // Running totals, published with nonblocking updates
    int fails;
    int checked;
    int dropped_results;
    int stalls;

    function automatic op_t decode_char(logic [CHAR_W-1:0] ch);
        op_t op;
        op = OP_NOP;
        if (ch >= CHAR_ONE && ch <= CHAR_NINE) op = OP_PUSH;
        else if (ch == CHAR_PLUS)               op = OP_ADD;
        else if (ch == CHAR_MINUS)              op = OP_SUB;
        else if (ch == CHAR_STAR)               op = OP_MUL;
        return op;
    endfunction

    // Empty stack reads as all ones
    function logic [VALUE_W-1:0] stack_top();
        if (stack_fill == 0) return EMPTY_VALUE;
        return stack_mem[stack_fill-1];
    endfunction

    function void stack_pop();
        if (stack_fill > 0) stack_fill--;
    endfunction

    // Push onto a full stack is lost but remembered
    function void stack_push(logic [VALUE_W-1:0] v);
        if (stack_fill >= STACK_DEPTH) begin
            push_dropped = 1'b1;
        end else begin
            stack_mem[stack_fill] = v;
            stack_fill++;
        end
    endfunction

    // Apply one character; queue a result when it closes an expression
    function void evaluate_char(logic [CHAR_W-1:0] ch, logic last);
        op_t                op;
        logic [VALUE_W-1:0] lhs;
        logic [VALUE_W-1:0] rhs;
        logic [VALUE_W-1:0] res;
        logic [CHAR_W-1:0]  digit;
        expr_result_t       r;
        op = decode_char(ch);
        case (op)
            OP_PUSH: begin
                digit = ch - CHAR_ZERO;
                stack_push({{(VALUE_W-CHAR_W){1'b0}}, digit});
            end
            OP_ADD, OP_SUB, OP_MUL: begin
                rhs = stack_top();
                stack_pop();
                lhs = stack_top();
                stack_pop();
                if (op == OP_ADD)      res = lhs + rhs;
                else if (op == OP_SUB) res = lhs - rhs;
                else                   res = lhs * rhs;
                stack_push(res);
            end
            default: ;
        endcase
        if (last) begin
            r.value      = stack_top();
            r.overflowed = push_dropped;
            expected_results.push_back(r);
            stack_pop();
            push_dropped = 1'b0;
        end
    endfunction

    // Compare result transfers, then fold in the accepted character
    always @(posedge aclk) begin
        expr_result_t exp_r;
        if (!aresetn) begin
            expected_results.delete();
            stack_fill   = 0;
            push_dropped = 1'b0;
        end else begin
            if (m_valid && m_ready) begin
                if (expected_results.size() == 0) begin
                    $display("%0t: unexpected result: value %0d, overflowed %0b",
                             $time, m_value, m_overflowed);
                    fails++;
                end else begin
                    exp_r = expected_results.pop_front();
                    checked++;
                    if (exp_r.overflowed) dropped_results++;
                    if (m_value !== exp_r.value) begin
                        $display("%0t: value mismatch: expected %0d, actual %0d",
                                 $time, $signed(exp_r.value), m_value);
                        fails++;
                    end
                    if (m_overflowed !== exp_r.overflowed) begin
                        $display("%0t: overflowed mismatch: expected %0b, actual %0b",
                                 $time, exp_r.overflowed, m_overflowed);
                        fails++;
                    end
                end
            end
            if (s_valid && !s_ready) stalls++;
            if (s_valid && s_ready) evaluate_char(s_character, s_last_char);
        end
        fail_count     <= fails;
        pending        <= expected_results.size();
        checked_count  <= checked;
        overflow_count <= dropped_results;
        stall_count    <= stalls;
    end

endmodule

[dv/tb.sv]
module tb;
    import pfe_pkg::*;

    localparam int ITEM_TARGET  = 1100;
    localparam int CYCLE_LIMIT  = 200000;
    localparam int DRAIN_CYCLES = 20;
    // Sender runs without gaps over this range of characters
    localparam int TX_CALM_FIRST = 500;
    localparam int TX_CALM_LAST  = 750;
    // Receiver hold-off and gap-free stretch, in receiver cycles
    localparam int HOLD_START  = 400;
    localparam int HOLD_CYCLES = 300;
    localparam int RX_CALM_START  = 900;
    localparam int RX_CALM_CYCLES = 300;

    logic                      aclk        = 1'b0;
    logic                      aresetn     = 1'b0;
    logic                      s_valid     = 1'b0;
    logic                      s_ready;
    logic [CHAR_W-1:0]         s_character = '0;
    logic                      s_last_char = 1'b0;
    logic                      m_valid;
    logic                      m_ready     = 1'b0;
    logic signed [VALUE_W-1:0] m_value;
    logic                      m_overflowed;

    int fail_count;
    int pending;
    int checked_count;
    int overflow_count;
    int stall_count;

    int items_sent   = 0;
    int shadow_depth = 0;
    int cycle_count  = 0;
    int rx_cycle     = 0;

    postfix_expression_evaluator dut (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .s_valid      (s_valid),
        .s_ready      (s_ready),
        .s_character  (s_character),
        .s_last_char  (s_last_char),
        .m_valid      (m_valid),
        .m_ready      (m_ready),
        .m_value      (m_value),
        .m_overflowed (m_overflowed)
    );

    postfix_checker u_checker (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_character    (s_character),
        .s_last_char    (s_last_char),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_value        (m_value),
        .m_overflowed   (m_overflowed),
        .fail_count     (fail_count),
        .pending        (pending),
        .checked_count  (checked_count),
        .overflow_count (overflow_count),
        .stall_count    (stall_count)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    // Run limit
    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("%0t: timeout after %0d cycles", $time, cycle_count);
            $display("Verification failed");
            $finish;
        end
    end

    // Receiver: random gaps, one long hold-off, one gap-free stretch
    always @(posedge aclk) begin
        rx_cycle <= rx_cycle + 1;
        if (rx_cycle >= HOLD_START && rx_cycle < HOLD_START + HOLD_CYCLES)
            m_ready <= 1'b0;
        else if (rx_cycle >= RX_CALM_START && rx_cycle < RX_CALM_START + RX_CALM_CYCLES)
            m_ready <= 1'b1;
        else
            m_ready <= ($urandom_range(99) >= 11);
    end

    // One input transfer, with an optional gap in front; tracks stack depth
    task automatic send_char(logic [CHAR_W-1:0] ch, logic last);
        if ($urandom_range(99) < 11 &&
            !(items_sent >= TX_CALM_FIRST && items_sent < TX_CALM_LAST)) begin
            s_valid <= 1'b0;
            repeat ($urandom_range(1, 2)) @(posedge aclk);
        end
        s_valid     <= 1'b1;
        s_character <= ch;
        s_last_char <= last;
        do @(posedge aclk); while (!s_ready);
        items_sent++;
        if (ch >= CHAR_ONE && ch <= CHAR_NINE) begin
            if (shadow_depth < STACK_DEPTH) shadow_depth++;
        end else if (ch == CHAR_PLUS || ch == CHAR_MINUS || ch == CHAR_STAR) begin
            shadow_depth = ((shadow_depth >= 2) ? shadow_depth - 2 : 0) + 1;
        end
        if (last && shadow_depth > 0) shadow_depth--;
    endtask

    function automatic logic [CHAR_W-1:0] rand_digit();
        return CHAR_ONE + CHAR_W'($urandom_range(8));
    endfunction

    function automatic logic [CHAR_W-1:0] rand_op();
        case ($urandom_range(2))
            0:       return CHAR_PLUS;
            1:       return CHAR_MINUS;
            default: return CHAR_STAR;
        endcase
    endfunction

    initial begin : stimulus
        logic [CHAR_W-1:0] expr_chars[$];
        logic              end_mark;
        int                kind;
        int                operands;
        int                pushed;
        int                local_depth;
        bit                keep_leftovers;
        int                n;

        repeat (4) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Directed: empty reads, ignored characters, extremes, every operator
        send_char(8'h00, 1'b1);                       // empty stack result
        send_char(CHAR_PLUS, 1'b1);                   // operator on empty stack
        send_char(CHAR_ZERO, 1'b1);                   // zero is ignored
        send_char(CHAR_NINE, 1'b0);
        send_char(CHAR_NINE, 1'b0);
        send_char(CHAR_STAR, 1'b1);                   // 81
        send_char(CHAR_ONE, 1'b0);
        send_char(CHAR_NINE, 1'b0);
        send_char(CHAR_MINUS, 1'b1);                  // negative difference
        send_char(CHAR_ZERO + 8'd5, 1'b0);
        send_char(8'hFF, 1'b0);                       // unknown character
        send_char(CHAR_ZERO + 8'd3, 1'b0);
        send_char(CHAR_STAR, 1'b1);
        send_char(CHAR_ZERO + 8'd7, 1'b0);
        send_char(CHAR_MINUS, 1'b1);                  // one operand missing
        send_char(CHAR_ONE, 1'b0);
        send_char(CHAR_ZERO + 8'd2, 1'b1);            // leaves an entry behind
        send_char(CHAR_PLUS, 1'b1);                   // uses the leftover
        send_char(CHAR_NINE, 1'b1);                   // digit closes expression
        send_char(8'h80, 1'b1);

        // Random expressions, mostly well formed
        while (items_sent < ITEM_TARGET) begin
            expr_chars.delete();
            end_mark = 1'b1;
            kind = $urandom_range(99);
            if (kind < 70) begin
                // Drain a deep stack with leading operators
                if (shadow_depth > 40)
                    repeat (shadow_depth - $urandom_range(2, 6)) expr_chars.push_back(rand_op());
                operands       = $urandom_range(1, 8);
                keep_leftovers = ($urandom_range(99) < 25);
                pushed         = 0;
                local_depth    = 0;
                while (pushed < operands || (local_depth > 1 && !keep_leftovers)) begin
                    if (pushed < operands && (local_depth < 2 || $urandom_range(99) < 55)) begin
                        expr_chars.push_back(rand_digit());
                        pushed++;
                        local_depth++;
                    end else begin
                        expr_chars.push_back(rand_op());
                        local_depth--;
                    end
                    if ($urandom_range(99) < 5)
                        expr_chars.push_back(CHAR_W'($urandom_range(255)));
                end
            end else if (kind < 80) begin
                // Arbitrary bytes
                repeat ($urandom_range(1, 5)) expr_chars.push_back(CHAR_W'($urandom_range(255)));
                end_mark = $urandom_range(1);
            end else if (kind < 89) begin
                // Broken sequences of digits and operators
                repeat ($urandom_range(1, 10)) begin
                    if ($urandom_range(1)) expr_chars.push_back(rand_digit());
                    else                   expr_chars.push_back(rand_op());
                end
                end_mark = $urandom_range(1);
            end else if (kind < 97 || items_sent < 100) begin
                // Long products and differences that wrap
                expr_chars.push_back(CHAR_NINE);
                repeat ($urandom_range(8, 15)) begin
                    expr_chars.push_back(rand_digit() | 8'h08);
                    expr_chars.push_back(($urandom_range(3) == 0) ? CHAR_MINUS : CHAR_STAR);
                end
            end else begin
                // Fill past capacity so pushes are dropped
                n = STACK_DEPTH - shadow_depth + $urandom_range(1, 3);
                repeat (n) expr_chars.push_back(rand_digit());
            end
            foreach (expr_chars[i])
                send_char(expr_chars[i], (i == expr_chars.size() - 1) ? end_mark : 1'b0);
        end
        s_valid <= 1'b0;

        // Let outstanding results drain
        @(posedge aclk);
        while (pending != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);

        $display("Sent %0d characters; checked %0d expression results, %0d with a dropped push.",
                 items_sent, checked_count, overflow_count);
        $display("Input was held back by the block for %0d cycles.", stall_count);
        if (pending != 0)
            $display("%0t: %0d expected results never arrived", $time, pending);
        if (fail_count == 0 && pending == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule
